// ===== rtl/prtw_pkg.sv =====
// ----------------------------------------------------------------------------
// prtw_pkg
// Shared constants, codes and tables of the polyline resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package prtw_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MaxSamplesDef = 24;
  localparam int unsigned CoordWidthDef = 32;

  // Fixed field widths.
  localparam int unsigned SpacingW   = 24;
  localparam int unsigned WeightW    = 16;
  localparam int unsigned IdW        = 48;
  localparam int unsigned PortCoordW = 32;
  localparam int unsigned ZW         = 32;
  localparam int unsigned AngleW     = 18;

  // Register reset values.
  localparam logic [SpacingW-1:0] SpacingReset = 24'd256;
  localparam logic [WeightW-1:0]  WeightReset  = 16'd256;

  // Configuration register indexes.
  typedef enum logic {
    CFG_SPACING = 1'b0,
    CFG_WEIGHT  = 1'b1
  } cfg_reg_e;

  // Kinds of work handed from the front to the back.
  typedef enum logic {
    JOB_SEG   = 1'b0,
    JOB_POINT = 1'b1
  } job_kind_e;

  // Angle constants.
  localparam int unsigned     CordicSteps = 17;
  localparam logic [AngleW-1:0] PiQ16     = 18'd205887;

  // Depth of the job queue between front and back.
  localparam int unsigned JobFifoDepth = 4;

  // Width of one packed job for a given coordinate width.
  function automatic int unsigned job_w(input int unsigned cw);
    return 4 * cw + IdW + 2 * ZW + 3;
  endfunction

  // Arctangent table in Q16.16, one entry per CORDIC step.
  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30386;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/polyline_resample_turn_weight_unit.sv =====
// ----------------------------------------------------------------------------
// polyline_resample_turn_weight_unit
// Polyline resampler that weights each vertex by its turn angle.
// ----------------------------------------------------------------------------
// Vertices are pushed one per beat; from the third vertex of a polyline on,
// the front computes the turn angle at the middle vertex (a shrink loop, the
// dot and cross products, a normalizing loop, the CORDIC steps, clamping and
// weight scaling), and full stays high while it works and while the job queue
// is full; the first two vertices of a polyline are taken with full low.
// The back then searches the sample count n of each segment, divides by n
// bit-serially when n is above one and emits one point per cycle while the
// output register can take one; a four-entry job queue lets the front start
// the next vertex while the back is still emitting. Points leave through a
// single output register; a point the back has ready is offered after a pop.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i;
// the user must do so only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_resample_turn_weight_unit #(
  parameter int unsigned MAX_SAMPLES = prtw_pkg::MaxSamplesDef,
  parameter int unsigned COORD_WIDTH = prtw_pkg::CoordWidthDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [0:0]                             cfg_idx_i,
  input  wire logic [prtw_pkg::SpacingW-1:0]          cfg_wdata_i,
  input  wire logic                                   push_i,
  output logic                                        full_o,
  input  wire logic signed [prtw_pkg::PortCoordW-1:0] vertex_x_i,
  input  wire logic signed [prtw_pkg::PortCoordW-1:0] vertex_y_i,
  input  wire logic [prtw_pkg::IdW-1:0]               vertex_id_i,
  input  wire logic                                   last_vertex_i,
  output logic                                        empty_o,
  input  wire logic                                   pop_i,
  output logic signed [prtw_pkg::PortCoordW-1:0]      point_x_o,
  output logic signed [prtw_pkg::PortCoordW-1:0]      point_y_o,
  output logic [prtw_pkg::ZW-1:0]                     point_z_o,
  output logic [prtw_pkg::IdW-1:0]                    point_id_o,
  output logic                                        last_of_run_o,
  output logic                                        end_of_polyline_o,
  output logic                                        samples_clipped_o
);

  localparam int unsigned JobW = prtw_pkg::job_w(COORD_WIDTH);

  // Configuration registers.
  logic [prtw_pkg::SpacingW-1:0] spacing_q;
  logic [prtw_pkg::WeightW-1:0]  weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= prtw_pkg::SpacingReset;
      weight_q  <= prtw_pkg::WeightReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == prtw_pkg::CFG_SPACING) begin
        spacing_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == prtw_pkg::CFG_WEIGHT) begin
        weight_q <= cfg_wdata_i[prtw_pkg::WeightW-1:0];
      end
    end
  end

  logic [JobW-1:0] job_in, job_out;
  logic            job_push, job_full, job_pop, job_empty;

  // Front: vertex history and turn angle.
  prtw_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .JOB_W       (JobW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .vertex_id_i   (vertex_id_i),
    .last_vertex_i (last_vertex_i),
    .weight_i      (weight_q),
    .job_o         (job_in),
    .job_push_o    (job_push),
    .job_full_i    (job_full)
  );

  // Job queue.
  prtw_fifo #(
    .WIDTH (JobW),
    .DEPTH (prtw_pkg::JobFifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  // Back: sampling and result beats.
  prtw_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAX_SAMPLES (MAX_SAMPLES),
    .JOB_W       (JobW)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_i             (job_out),
    .job_empty_i       (job_empty),
    .job_pop_o         (job_pop),
    .spacing_i         (spacing_q),
    .empty_o           (empty_o),
    .pop_i             (pop_i),
    .point_x_o         (point_x_o),
    .point_y_o         (point_y_o),
    .point_z_o         (point_z_o),
    .point_id_o        (point_id_o),
    .last_of_run_o     (last_of_run_o),
    .end_of_polyline_o (end_of_polyline_o),
    .samples_clipped_o (samples_clipped_o)
  );

endmodule

`default_nettype wire

// ===== rtl/prtw_fifo.sv =====
// ----------------------------------------------------------------------------
// prtw_fifo
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module prtw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/prtw_front.sv =====
// ----------------------------------------------------------------------------
// prtw_front
// Takes vertices, keeps the previous two, computes the weighted turn angle
// with a sequential CORDIC and queues segment and end-point jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module prtw_front #(
  parameter int unsigned COORD_WIDTH = prtw_pkg::CoordWidthDef,
  parameter int unsigned JOB_W       = prtw_pkg::job_w(prtw_pkg::CoordWidthDef)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push_i,
  output logic                                     full_o,
  input  wire logic signed [prtw_pkg::PortCoordW-1:0] vertex_x_i,
  input  wire logic signed [prtw_pkg::PortCoordW-1:0] vertex_y_i,
  input  wire logic [prtw_pkg::IdW-1:0]            vertex_id_i,
  input  wire logic                                last_vertex_i,
  input  wire logic [prtw_pkg::WeightW-1:0]        weight_i,
  output logic [JOB_W-1:0]                         job_o,
  output logic                                     job_push_o,
  input  wire logic                                job_full_i
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned IdW = prtw_pkg::IdW;
  localparam int unsigned ZW = prtw_pkg::ZW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SHRINK, ST_MUL, ST_PREP, ST_NORM, ST_CORDIC,
    ST_FIN, ST_SCALE, ST_PUSH_A, ST_PUSH_B, ST_PUSH_C
  } state_e;

  state_e state_q, state_d;
  logic [1:0] seen_q, seen_d;

  // Vertex history and the vertex at work.
  logic signed [CW-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q, cur_x_q, cur_y_q;
  logic [IdW-1:0]       older_id_q, newer_id_q, cur_id_q;
  logic [ZW-1:0]        older_z_q, zn_q;
  logic                 cur_last_q;

  // Angle datapath.
  logic [DW-1:0]        uxm_q, uym_q, vxm_q, vym_q;
  logic                 uxn_q, uyn_q, vxn_q, vyn_q;
  logic [1:0]           step_q;
  logic signed [33:0]   dot_q, cr_q;
  logic [40:0]          ax_q, ay_q;
  logic signed [43:0]   cx_q, cy_q;
  logic signed [18:0]   ang_q;
  logic [4:0]           it_q;
  logic                 dot_neg_q;
  logic [prtw_pkg::AngleW-1:0] angr_q;

  // Input coordinates taken at the configured width.
  logic signed [CW-1:0] x_in, y_in;
  assign x_in = CW'($unsigned(vertex_x_i));
  assign y_in = CW'($unsigned(vertex_y_i));

  logic accept;
  assign accept = push_i && (state_q == ST_IDLE);
  assign full_o = (state_q != ST_IDLE);

  // Incoming and outgoing segment vectors.
  logic signed [DW-1:0] ux, uy, vx, vy;
  logic                 zero_vec;
  assign ux = DW'(newer_x_q) - DW'(older_x_q);
  assign uy = DW'(newer_y_q) - DW'(older_y_q);
  assign vx = DW'(x_in) - DW'(newer_x_q);
  assign vy = DW'(y_in) - DW'(newer_y_q);
  assign zero_vec = (ux == '0 && uy == '0) || (vx == '0 && vy == '0);

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // Shrink test: a vector is scaled down until both parts fit in 15 bits.
  logic big_u, big_v;
  assign big_u = ((uxm_q >> 15) != '0) || ((uym_q >> 15) != '0);
  assign big_v = ((vxm_q >> 15) != '0) || ((vym_q >> 15) != '0);

  function automatic logic signed [15:0] small_op(input logic [DW-1:0] m, input logic n);
    logic signed [15:0] p;
    p = $signed({1'b0, 15'(m)});
    return n ? -p : p;
  endfunction

  // One shared multiplier for the four dot and cross products.
  logic signed [15:0] op_a, op_b;
  logic signed [31:0] prod;
  always_comb begin
    case (step_q)
      2'd0: begin
        op_a = small_op(uxm_q, uxn_q);
        op_b = small_op(vxm_q, vxn_q);
      end
      2'd1: begin
        op_a = small_op(uym_q, uyn_q);
        op_b = small_op(vym_q, vyn_q);
      end
      2'd2: begin
        op_a = small_op(uxm_q, uxn_q);
        op_b = small_op(vym_q, vyn_q);
      end
      default: begin
        op_a = small_op(uym_q, uyn_q);
        op_b = small_op(vxm_q, vxn_q);
      end
    endcase
  end
  assign prod = op_a * op_b;

  // CORDIC step terms.
  logic signed [43:0]  sx, sy;
  logic signed [18:0]  atan_s;
  assign sx     = cx_q >>> it_q;
  assign sy     = cy_q >>> it_q;
  assign atan_s = $signed({2'b00, prtw_pkg::atan_q16(it_q)});

  // Clamp of the angle to 0..pi; the reversal for an obtuse turn is applied in ST_FIN.
  logic [prtw_pkg::AngleW-1:0] ang_cl;
  always_comb begin
    if (ang_q < 0) begin
      ang_cl = '0;
    end else if (ang_q > $signed({1'b0, prtw_pkg::PiQ16})) begin
      ang_cl = prtw_pkg::PiQ16;
    end else begin
      ang_cl = ang_q[prtw_pkg::AngleW-1:0];
    end
  end

  logic [33:0] wprod;
  assign wprod = 34'(angr_q) * 34'(weight_i);

  // Control state.
  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    case (state_q)
      ST_IDLE: begin
        if (push_i) begin
          case (seen_q)
            2'd0:    seen_d = last_vertex_i ? 2'd0 : 2'd1;
            2'd1:    seen_d = last_vertex_i ? 2'd0 : 2'd2;
            default: state_d = zero_vec ? ST_FIN : ST_SHRINK;
          endcase
        end
      end
      ST_SHRINK: if (!big_u && !big_v) state_d = ST_MUL;
      ST_MUL:    if (step_q == 2'd3) state_d = ST_PREP;
      ST_PREP:   state_d = (cr_q == '0) ? ST_FIN : ST_NORM;
      ST_NORM:   if (ax_q[40] || ay_q[40]) state_d = ST_CORDIC;
      ST_CORDIC: if (it_q == 5'(prtw_pkg::CordicSteps - 1)) state_d = ST_FIN;
      ST_FIN:    state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_PUSH_A;
      ST_PUSH_A: begin
        if (!job_full_i) begin
          if (cur_last_q) begin
            state_d = ST_PUSH_B;
          end else begin
            state_d = ST_IDLE;
            seen_d  = 2'd2;
          end
        end
      end
      ST_PUSH_B: if (!job_full_i) state_d = ST_PUSH_C;
      ST_PUSH_C: begin
        if (!job_full_i) begin
          state_d = ST_IDLE;
          seen_d  = 2'd0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (seen_q)
            2'd0: begin
              older_x_q  <= x_in;
              older_y_q  <= y_in;
              older_id_q <= vertex_id_i;
              older_z_q  <= '0;
            end
            2'd1: begin
              newer_x_q  <= x_in;
              newer_y_q  <= y_in;
              newer_id_q <= vertex_id_i;
            end
            default: begin
              cur_x_q    <= x_in;
              cur_y_q    <= y_in;
              cur_id_q   <= vertex_id_i;
              cur_last_q <= last_vertex_i;
              uxm_q <= mag(ux);
              uym_q <= mag(uy);
              vxm_q <= mag(vx);
              vym_q <= mag(vy);
              uxn_q <= ux[DW-1];
              uyn_q <= uy[DW-1];
              vxn_q <= vx[DW-1];
              vyn_q <= vy[DW-1];
              ang_q     <= '0;
              dot_neg_q <= 1'b0;
            end
          endcase
        end
      end
      ST_SHRINK: begin
        if (big_u) begin
          uxm_q <= uxm_q >> 1;
          uym_q <= uym_q >> 1;
        end
        if (big_v) begin
          vxm_q <= vxm_q >> 1;
          vym_q <= vym_q >> 1;
        end
        step_q <= 2'd0;
      end
      ST_MUL: begin
        case (step_q)
          2'd0:    dot_q <= 34'(prod);
          2'd1:    dot_q <= dot_q + 34'(prod);
          2'd2:    cr_q  <= 34'(prod);
          default: cr_q  <= cr_q - 34'(prod);
        endcase
        step_q <= step_q + 2'd1;
      end
      ST_PREP: begin
        ax_q      <= dot_q[33] ? 41'(-dot_q) : 41'(dot_q);
        ay_q      <= cr_q[33] ? 41'(-cr_q) : 41'(cr_q);
        dot_neg_q <= dot_q[33];
        ang_q     <= '0;
      end
      ST_NORM: begin
        if (!ax_q[40] && !ay_q[40]) begin
          ax_q <= ax_q << 1;
          ay_q <= ay_q << 1;
        end else begin
          cx_q  <= $signed(44'(ax_q));
          cy_q  <= $signed(44'(ay_q));
          it_q  <= '0;
          ang_q <= '0;
        end
      end
      ST_CORDIC: begin
        if (!cy_q[43]) begin
          cx_q  <= cx_q + sy;
          cy_q  <= cy_q - sx;
          ang_q <= ang_q + atan_s;
        end else begin
          cx_q  <= cx_q - sy;
          cy_q  <= cy_q + sx;
          ang_q <= ang_q - atan_s;
        end
        it_q <= it_q + 5'd1;
      end
      ST_FIN: begin
        angr_q <= dot_neg_q ? (prtw_pkg::PiQ16 - ang_cl) : ang_cl;
      end
      ST_SCALE: begin
        zn_q <= ZW'(wprod[33:8]);
      end
      ST_PUSH_A: begin
        if (!job_full_i && !cur_last_q) begin
          older_x_q  <= newer_x_q;
          older_y_q  <= newer_y_q;
          older_id_q <= newer_id_q;
          older_z_q  <= zn_q;
          newer_x_q  <= cur_x_q;
          newer_y_q  <= cur_y_q;
          newer_id_q <= cur_id_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Job packing: {kind, eop, lor, z1, z0, id, y1, x1, y0, x0}.
  always_comb begin
    job_push_o = 1'b0;
    job_o      = {prtw_pkg::JOB_SEG, 1'b0, !cur_last_q, zn_q, older_z_q, newer_id_q,
                  newer_y_q, newer_x_q, older_y_q, older_x_q};
    case (state_q)
      ST_PUSH_A: job_push_o = !job_full_i;
      ST_PUSH_B: begin
        job_push_o = !job_full_i;
        job_o = {prtw_pkg::JOB_SEG, 1'b0, 1'b0, ZW'(0), zn_q, cur_id_q,
                 cur_y_q, cur_x_q, newer_y_q, newer_x_q};
      end
      ST_PUSH_C: begin
        job_push_o = !job_full_i;
        job_o = {prtw_pkg::JOB_POINT, 1'b1, 1'b1, ZW'(0), ZW'(0), cur_id_q,
                 cur_y_q, cur_x_q, cur_y_q, cur_x_q};
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/prtw_back.sv =====
// ----------------------------------------------------------------------------
// prtw_back
// Carries out queued jobs: counts samples of a segment, divides the segment
// by a count above one once, then steps along it and emits one point per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module prtw_back #(
  parameter int unsigned COORD_WIDTH = prtw_pkg::CoordWidthDef,
  parameter int unsigned MAX_SAMPLES = prtw_pkg::MaxSamplesDef,
  parameter int unsigned JOB_W       = prtw_pkg::job_w(prtw_pkg::CoordWidthDef)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [JOB_W-1:0]                  job_i,
  input  wire logic                              job_empty_i,
  output logic                                   job_pop_o,
  input  wire logic [prtw_pkg::SpacingW-1:0]     spacing_i,
  output logic                                   empty_o,
  input  wire logic                              pop_i,
  output logic signed [prtw_pkg::PortCoordW-1:0] point_x_o,
  output logic signed [prtw_pkg::PortCoordW-1:0] point_y_o,
  output logic [prtw_pkg::ZW-1:0]                point_z_o,
  output logic [prtw_pkg::IdW-1:0]               point_id_o,
  output logic                                   last_of_run_o,
  output logic                                   end_of_polyline_o,
  output logic                                   samples_clipped_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned DW   = COORD_WIDTH + 1;
  localparam int unsigned IdW  = prtw_pkg::IdW;
  localparam int unsigned ZW   = prtw_pkg::ZW;
  localparam int unsigned NW   = $clog2(MAX_SAMPLES + 2);
  localparam int unsigned RW   = NW + 1;
  localparam int unsigned NsW  = prtw_pkg::SpacingW + NW;
  localparam int unsigned SqW  = 2 * NsW;
  localparam int unsigned D2W  = 59;
  localparam int unsigned CmpW = (SqW > D2W) ? SqW : D2W;
  localparam int unsigned DcW  = $clog2(DW + 1);

  localparam int unsigned OY0  = CW;
  localparam int unsigned OX1  = 2 * CW;
  localparam int unsigned OY1  = 3 * CW;
  localparam int unsigned OID  = 4 * CW;
  localparam int unsigned OZ0  = OID + IdW;
  localparam int unsigned OZ1  = OZ0 + ZW;
  localparam int unsigned OLOR = OZ1 + ZW;
  localparam int unsigned OEOP = OLOR + 1;
  localparam int unsigned OKND = OEOP + 1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SQX, ST_SQY, ST_CSQ, ST_CCMP, ST_DECIDE, ST_DIV, ST_EMIT, ST_ONE
  } state_e;

  state_e state_q, state_d;

  // Job fields at the queue head.
  logic signed [CW-1:0] j_x0, j_y0, j_x1, j_y1;
  assign j_x0 = $signed(job_i[CW-1:0]);
  assign j_y0 = $signed(job_i[OY0 +: CW]);
  assign j_x1 = $signed(job_i[OX1 +: CW]);
  assign j_y1 = $signed(job_i[OY1 +: CW]);

  logic signed [DW-1:0] j_dx, j_dy;
  assign j_dx = DW'(j_x1) - DW'(j_x0);
  assign j_dy = DW'(j_y1) - DW'(j_y0);

  logic [DW-1:0] j_mx, j_my;
  logic          j_huge;
  assign j_mx   = j_dx[DW-1] ? DW'(-j_dx) : DW'(j_dx);
  assign j_my   = j_dy[DW-1] ? DW'(-j_dy) : DW'(j_dy);
  assign j_huge = ((j_mx >> 29) != '0) || ((j_my >> 29) != '0);

  // Latched job.
  logic signed [CW-1:0] x0_q, y0_q;
  logic [IdW-1:0]       id_q;
  logic [ZW-1:0]        z0_q, z1_q;
  logic                 lor_q, eop_q, clip_q;
  logic                 xn_q, yn_q;
  logic [DW-1:0]        mx_q, my_q;
  logic [prtw_pkg::SpacingW-1:0] s_q;

  // Sample count search.
  logic [NW-1:0]  n_q;
  logic [NsW-1:0] ns_q;
  logic [SqW-1:0] sq_q;
  logic [D2W-1:0] d2_q;
  logic [28:0]    sq_in;
  logic [57:0]    sq_out;
  assign sq_in  = (state_q == ST_SQX) ? 29'(mx_q) : 29'(my_q);
  assign sq_out = sq_in * sq_in;

  logic fits;
  assign fits = CmpW'(sq_q) <= CmpW'(d2_q);

  logic [NW-1:0] n_eff;
  logic          over;
  assign over  = n_q > NW'(MAX_SAMPLES);
  assign n_eff = over ? NW'(MAX_SAMPLES) : n_q;

  // Restoring divider of both magnitudes by the count, one bit a cycle.
  logic [DW-1:0]  qx_q, qy_q;
  logic [RW-1:0]  rx_q, ry_q;
  logic [DcW-1:0] dcnt_q;
  logic [RW-1:0]  rx_sh, ry_sh;
  logic           gx, gy;
  assign rx_sh = {rx_q[RW-2:0], qx_q[DW-1]};
  assign ry_sh = {ry_q[RW-2:0], qy_q[DW-1]};
  assign gx    = rx_sh >= RW'(n_q);
  assign gy    = ry_sh >= RW'(n_q);

  // Stepping accumulators.
  logic [DW-1:0] ax_q, ay_q;
  logic [RW-1:0] arx_q, ary_q;
  logic [NW-1:0] i_q;
  logic [DW-1:0] ax_s, ay_s;
  logic [RW-1:0] arx_s, ary_s;
  assign ax_s  = ax_q + qx_q;
  assign ay_s  = ay_q + qy_q;
  assign arx_s = arx_q + rx_q;
  assign ary_s = ary_q + ry_q;

  logic last_i;
  assign last_i = (i_q == NW'(n_q - 1'b1));

  // Sample position.
  logic signed [DW-1:0] offx, offy, sumx, sumy;
  logic signed [CW-1:0] px, py;
  assign offx = xn_q ? -$signed(ax_q) : $signed(ax_q);
  assign offy = yn_q ? -$signed(ay_q) : $signed(ay_q);
  assign sumx = DW'(x0_q) + offx;
  assign sumy = DW'(y0_q) + offy;
  assign px   = CW'(sumx);
  assign py   = CW'(sumy);

  // Output register.
  logic out_valid_q, can_load, load;
  assign can_load  = !out_valid_q || pop_i;
  assign empty_o   = !out_valid_q;
  assign load      = can_load && (state_q == ST_EMIT || state_q == ST_ONE);
  assign job_pop_o = (state_q == ST_LOAD) && !job_empty_i;

  // Control state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (!job_empty_i) begin
          if (job_i[OKND] == prtw_pkg::JOB_POINT) begin
            state_d = ST_ONE;
          end else begin
            state_d = j_huge ? ST_DECIDE : ST_SQX;
          end
        end
      end
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_CSQ;
      ST_CSQ:  state_d = ST_CCMP;
      ST_CCMP: begin
        if (!fits || n_q == NW'(MAX_SAMPLES)) begin
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_CSQ;
        end
      end
      ST_DECIDE: state_d = (n_eff > NW'(1)) ? ST_DIV : ST_ONE;
      ST_DIV:    if (dcnt_q == DcW'(DW - 1)) state_d = ST_EMIT;
      ST_EMIT:   if (can_load && last_i) state_d = ST_LOAD;
      ST_ONE:    if (can_load) state_d = ST_LOAD;
      default:   state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        if (!job_empty_i) begin
          x0_q   <= j_x0;
          y0_q   <= j_y0;
          id_q   <= job_i[OID +: IdW];
          z0_q   <= job_i[OZ0 +: ZW];
          z1_q   <= job_i[OZ1 +: ZW];
          lor_q  <= job_i[OLOR];
          eop_q  <= job_i[OEOP];
          clip_q <= 1'b0;
          xn_q   <= j_dx[DW-1];
          yn_q   <= j_dy[DW-1];
          mx_q   <= j_mx;
          my_q   <= j_my;
          s_q    <= (spacing_i == '0) ? prtw_pkg::SpacingW'(1) : spacing_i;
          n_q    <= j_huge ? NW'(MAX_SAMPLES + 1) : '0;
        end
      end
      ST_SQX: begin
        d2_q <= D2W'(sq_out);
        ns_q <= NsW'(s_q);
      end
      ST_SQY: d2_q <= d2_q + D2W'(sq_out);
      ST_CSQ: sq_q <= SqW'(ns_q) * SqW'(ns_q);
      ST_CCMP: begin
        if (fits) begin
          n_q  <= n_q + 1'b1;
          ns_q <= ns_q + NsW'(s_q);
        end
      end
      ST_DECIDE: begin
        clip_q <= over;
        n_q    <= n_eff;
        qx_q   <= mx_q;
        qy_q   <= my_q;
        rx_q   <= '0;
        ry_q   <= '0;
        dcnt_q <= '0;
      end
      ST_DIV: begin
        rx_q   <= gx ? rx_sh - RW'(n_q) : rx_sh;
        ry_q   <= gy ? ry_sh - RW'(n_q) : ry_sh;
        qx_q   <= {qx_q[DW-2:0], gx};
        qy_q   <= {qy_q[DW-2:0], gy};
        dcnt_q <= dcnt_q + 1'b1;
        ax_q   <= '0;
        ay_q   <= '0;
        arx_q  <= '0;
        ary_q  <= '0;
        i_q    <= '0;
      end
      ST_EMIT: begin
        if (can_load) begin
          if (arx_s >= RW'(n_q)) begin
            ax_q  <= ax_s + 1'b1;
            arx_q <= arx_s - RW'(n_q);
          end else begin
            ax_q  <= ax_s;
            arx_q <= arx_s;
          end
          if (ary_s >= RW'(n_q)) begin
            ay_q  <= ay_s + 1'b1;
            ary_q <= ary_s - RW'(n_q);
          end else begin
            ay_q  <= ay_s;
            ary_q <= ary_s;
          end
          i_q <= i_q + 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Result beat.
    if (load) begin
      point_id_o        <= id_q;
      samples_clipped_o <= clip_q;
      end_of_polyline_o <= eop_q;
      if (state_q == ST_ONE) begin
        point_x_o     <= prtw_pkg::PortCoordW'(x0_q);
        point_y_o     <= prtw_pkg::PortCoordW'(y0_q);
        point_z_o     <= z0_q;
        last_of_run_o <= lor_q;
      end else begin
        point_x_o     <= prtw_pkg::PortCoordW'(px);
        point_y_o     <= prtw_pkg::PortCoordW'(py);
        point_z_o     <= (i_q == '0) ? z0_q : (last_i ? z1_q : '0);
        last_of_run_o <= lor_q && last_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/prtw_checker.sv =====
// ----------------------------------------------------------------------------
// prtw_checker
// Port-level checks of the polyline resampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prtw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic [0:0]  cfg_idx_i,
  input wire logic [23:0] cfg_wdata_i,
  input wire logic        push_i,
  input wire logic        full_o,
  input wire logic [31:0] vertex_x_i,
  input wire logic [31:0] vertex_y_i,
  input wire logic [47:0] vertex_id_i,
  input wire logic        last_vertex_i,
  input wire logic        empty_o,
  input wire logic        pop_i,
  input wire logic [31:0] point_x_o,
  input wire logic [31:0] point_y_o,
  input wire logic [31:0] point_z_o,
  input wire logic [47:0] point_id_o,
  input wire logic        last_of_run_o,
  input wire logic        end_of_polyline_o,
  input wire logic        samples_clipped_o
);

  // The final point of a polyline also closes the run of its vertex.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && end_of_polyline_o |-> last_of_run_o)
    else $error("end of polyline without end of run");

  // The end point carries zero weight and is never clipped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && end_of_polyline_o |-> point_z_o == 32'd0 && !samples_clipped_o)
    else $error("end point carries weight or clip flag");

  // A waiting result beat holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(point_x_o) && $stable(point_id_o))
    else $error("waiting result beat changed");

endmodule

bind polyline_resample_turn_weight_unit prtw_checker u_prtw_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the polyline resampler with turn weighting.
// Vertices are pushed into the block and every resampled point is
// compared field by field against a built-in predictor of the block. Both
// sides idle at random, the receiver holds off long enough to fill the
// block, and the registers are swept through their extreme settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int unsigned MaxPts     = prtw_pkg::MaxSamplesDef;
  localparam int          WatchLimit = 20000;
  localparam int          DrainWait  = 300;

  // One expected resampled point.
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [47:0] id;
    bit          lor;
    bit          eop;
    bit          clip;
  } point_t;

  // Arctangent steps in Q16.16.
  localparam longint AtanTab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2, 1};

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [0:0]                      cfg_idx_i = '0;
  logic [prtw_pkg::SpacingW-1:0]   cfg_wdata_i = '0;
  logic                            push_i = 1'b0;
  logic                            full_o;
  logic signed [31:0]              vertex_x_i = '0;
  logic signed [31:0]              vertex_y_i = '0;
  logic [prtw_pkg::IdW-1:0]        vertex_id_i = '0;
  logic                            last_vertex_i = 1'b0;
  logic                            empty_o;
  logic                            pop_i = 1'b0;
  logic signed [31:0]              point_x_o;
  logic signed [31:0]              point_y_o;
  logic [prtw_pkg::ZW-1:0]         point_z_o;
  logic [prtw_pkg::IdW-1:0]        point_id_o;
  logic                            last_of_run_o;
  logic                            end_of_polyline_o;
  logic                            samples_clipped_o;

  // Predictor state and registers.
  logic [23:0] spacing_q;
  logic [15:0] weight_q;
  longint      old_x, old_y, new_x, new_y;
  logic [47:0] old_id, new_id;
  logic [31:0] old_z;
  int          buffered;

  point_t exp_points[$];
  int     errors = 0;
  int     hold_left = 0;

  polyline_resample_turn_weight_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push_i, .full_o, .vertex_x_i, .vertex_y_i, .vertex_id_i, .last_vertex_i,
    .empty_o, .pop_i, .point_x_o, .point_y_o, .point_z_o, .point_id_o,
    .last_of_run_o, .end_of_polyline_o, .samples_clipped_o
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, sometimes long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Shrinks a vector until both magnitudes are below 2^15.
  function automatic void shrink_vec(inout longint a, inout longint b);
    longint ma, mb;
    ma = mag(a);
    mb = mag(b);
    while (ma >= 32768 || mb >= 32768) begin
      ma = ma >> 1;
      mb = mb >> 1;
    end
    a = (a < 0) ? -ma : ma;
    b = (b < 0) ? -mb : mb;
  endfunction

  // Turn angle in Q16.16 between vectors u and v, by CORDIC vectoring.
  function automatic longint turn_angle(longint ux, longint uy, longint vx, longint vy);
    longint dot, cr, ang, cx, cy, nx, ax, ay;
    if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0)) return 0;
    shrink_vec(ux, uy);
    shrink_vec(vx, vy);
    dot = ux * vx + uy * vy;
    cr  = ux * vy - uy * vx;
    ax  = mag(dot);
    ay  = mag(cr);
    ang = 0;
    if (ay != 0) begin
      while (ax < (64'sd1 << 40) && ay < (64'sd1 << 40)) begin
        ax = ax << 1;
        ay = ay << 1;
      end
      cx = ax;
      cy = ay;
      for (int i = 0; i < 17; i++) begin
        if (cy >= 0) begin
          nx  = cx + (cy >>> i);
          cy  = cy - (cx >>> i);
          ang += AtanTab[i];
        end else begin
          nx  = cx - (cy >>> i);
          cy  = cy + (cx >>> i);
          ang -= AtanTab[i];
        end
        cx = nx;
      end
    end
    if (ang < 0) ang = 0;
    if (ang > longint'(prtw_pkg::PiQ16)) ang = longint'(prtw_pkg::PiQ16);
    if (dot < 0) ang = longint'(prtw_pkg::PiQ16) - ang;
    return ang;
  endfunction

  function automatic void add_point(longint x, longint y, logic [31:0] z,
                                    logic [47:0] id, bit clip);
    point_t p;
    p.x = x[31:0];
    p.y = y[31:0];
    p.z = z;
    p.id = id;
    p.lor = 1'b0;
    p.eop = 1'b0;
    p.clip = clip;
    exp_points.insert(exp_points.size(), p);
  endfunction

  // Expected samples of one segment.
  function automatic void resample_segment(longint x0, longint y0, longint x1, longint y1,
                                           logic [47:0] id, logic [31:0] z0,
                                           logic [31:0] z1);
    longint dx, dy, s, d2, ns;
    bit huge, clip;
    int cnt;
    logic [31:0] z;
    dx = x1 - x0;
    dy = y1 - y0;
    s = (spacing_q == 0) ? 1 : spacing_q;
    huge = mag(dx) >= (64'sd1 << 29) || mag(dy) >= (64'sd1 << 29);
    d2 = huge ? 0 : dx * dx + dy * dy;
    cnt = 0;
    while (cnt <= MaxPts) begin
      ns = (cnt + 1) * s;
      if (huge || ns * ns <= d2) cnt++;
      else break;
    end
    clip = cnt > MaxPts;
    if (clip) cnt = MaxPts;
    if (cnt > 1) begin
      for (int i = 0; i < cnt; i++) begin
        z = (i == 0) ? z0 : (i == cnt - 1) ? z1 : 32'd0;
        add_point(x0 + (dx * i) / cnt, y0 + (dy * i) / cnt, z, id, clip);
      end
    end else begin
      add_point(x0, y0, z0, id, clip);
    end
  endfunction

  // Advances the predictor by one accepted vertex.
  function automatic void predict_vertex(longint x, longint y, logic [47:0] id, bit last);
    longint p;
    logic [31:0] zn;
    if (buffered == 0) begin
      old_x = x; old_y = y; old_id = id; old_z = '0;
      buffered = last ? 0 : 1;
      return;
    end
    if (buffered == 1) begin
      new_x = x; new_y = y; new_id = id;
      buffered = last ? 0 : 2;
      return;
    end
    p = (turn_angle(new_x - old_x, new_y - old_y, x - new_x, y - new_y) * weight_q) >> 8;
    zn = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    resample_segment(old_x, old_y, new_x, new_y, new_id, old_z, zn);
    if (last) begin
      resample_segment(new_x, new_y, x, y, id, zn, 32'd0);
      add_point(x, y, 32'd0, id, 1'b0);
      exp_points[exp_points.size() - 1].eop = 1'b1;
      buffered = 0;
    end else begin
      old_x = new_x; old_y = new_y; old_id = new_id; old_z = zn;
      new_x = x; new_y = y; new_id = id;
      buffered = 2;
    end
    exp_points[exp_points.size() - 1].lor = 1'b1;
  endfunction

  // Sends one vertex and waits for its beat; push stays high afterwards.
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [47:0] id, bit last);
    vertex_x_i    <= x;
    vertex_y_i    <= y;
    vertex_id_i   <= id;
    last_vertex_i <= last;
    push_i        <= 1'b1;
    do @(posedge clk_i); while (full_o);
    predict_vertex(longint'($signed(x)), longint'($signed(y)), id, last);
  endtask

  // Optional random pause of the sender.
  task automatic sender_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      push_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Waits until every expected point has arrived and the block has settled.
  task automatic drain();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (exp_points.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(prtw_pkg::cfg_reg_e idx, logic [23:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == prtw_pkg::CFG_SPACING) spacing_q = val;
    else weight_q = val[15:0];
  endtask

  function automatic logic [47:0] rand_id();
    return {$urandom(), $urandom()};
  endfunction

  // Short polylines covering the special cases at default registers.
  task automatic test_directed();
    send_vertex(32'd5, 32'd5, 48'd1, 1'b1);                   // lone vertex
    send_vertex(32'd0, 32'd0, 48'd2, 1'b0);                   // two vertices only
    send_vertex(32'd1000, 32'd0, 48'd3, 1'b1);
    // Straight line, then exact reversal, then a zero-length segment.
    send_vertex(32'd0, 32'd0, 48'd0, 1'b0);
    send_vertex(32'd1024, 32'd0, 48'd4, 1'b0);
    send_vertex(32'd2048, 32'd0, 48'd5, 1'b0);
    send_vertex(32'd1024, 32'd0, 48'd6, 1'b0);
    send_vertex(32'd1024, 32'd0, 48'd7, 1'b0);
    send_vertex(32'd1024, 32'd900, 48'hFFFF_FFFF_FFFF, 1'b1); // right angle at end
    // Coordinate extremes give saturated sample counts.
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 48'hAAAA_AAAA_AAAA, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 48'h5555_5555_5555, 1'b0);
    send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd8, 1'b0);
    send_vertex(32'h8000_0000, 32'h8000_0000, 48'd9, 1'b1);
    // Negative coordinates with a sharp turn.
    send_vertex(-32'sd3000, -32'sd3000, 48'd10, 1'b0);
    send_vertex(-32'sd100, -32'sd2000, 48'd11, 1'b0);
    send_vertex(-32'sd2900, -32'sd2950, 48'd12, 1'b1);
    drain();
  endtask

  // Extreme register settings, each with a short polyline.
  task automatic test_register_sweep();
    logic [23:0] spacings[4] = '{24'd1, 24'hFF_FFFF, 24'd0, 24'd300};
    logic [15:0] weights[4]  = '{16'hFFFF, 16'd0, 16'd1, 16'd256};
    for (int k = 0; k < 4; k++) begin
      write_reg(prtw_pkg::CFG_SPACING, spacings[k]);
      write_reg(prtw_pkg::CFG_WEIGHT, {8'd0, weights[k]});
      send_vertex(32'd100, 32'd100, rand_id(), 1'b0);
      send_vertex(32'd2100, 32'd300, rand_id(), 1'b0);
      send_vertex(32'd40, 32'd2100, rand_id(), 1'b0);
      send_vertex(32'd50, 32'd2100, rand_id(), 1'b1);
      drain();
    end
  endtask

  // One random polyline near a random origin, with noisy vertices now and then.
  task automatic random_polyline(int nv, inout int sent);
    logic [31:0] bx, by;
    int r;
    bx = $urandom();
    by = $urandom();
    for (int v = 0; v < nv; v++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        bx = bx + $urandom_range(0, 8192) - 4096;
        by = by + $urandom_range(0, 8192) - 4096;
      end else if (r < 90) begin
        bx = $urandom();
        by = $urandom();
      end
      send_vertex(bx, by, rand_id(), v == nv - 1);
      sent++;
      sender_gap();
    end
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    write_reg(prtw_pkg::CFG_SPACING, 24'($urandom_range(64, 1024)));
    write_reg(prtw_pkg::CFG_WEIGHT, {8'd0, 16'($urandom())});
    while (sent < 150) random_polyline($urandom_range(1, 8), sent);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering vertices.
  task automatic test_backpressure();
    int sent;
    sent = 0;
    write_reg(prtw_pkg::CFG_SPACING, 24'd256);
    hold_left = 600;
    random_polyline(8, sent);
    random_polyline(8, sent);
    drain();
  endtask

  // Result side: random pops, compare each beat with the oldest expectation.
  initial begin
    point_t e;
    int stall;
    logic nxt;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) begin
        if (exp_points.size() == 0) begin
          $error("point with no expectation: x=%0h y=%0h", point_x_o, point_y_o);
          errors++;
        end else begin
          e = exp_points.pop_front();
          if (point_x_o !== e.x) begin
            $error("point_x expected %0h got %0h", e.x, point_x_o); errors++;
          end
          if (point_y_o !== e.y) begin
            $error("point_y expected %0h got %0h", e.y, point_y_o); errors++;
          end
          if (point_z_o !== e.z) begin
            $error("point_z expected %0h got %0h", e.z, point_z_o); errors++;
          end
          if (point_id_o !== e.id) begin
            $error("point_id expected %0h got %0h", e.id, point_id_o); errors++;
          end
          if (last_of_run_o !== e.lor) begin
            $error("last_of_run expected %0b got %0b", e.lor, last_of_run_o); errors++;
          end
          if (end_of_polyline_o !== e.eop) begin
            $error("end_of_polyline expected %0b got %0b", e.eop, end_of_polyline_o);
            errors++;
          end
          if (samples_clipped_o !== e.clip) begin
            $error("samples_clipped expected %0b got %0b", e.clip, samples_clipped_o);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (stall > 0) begin
        stall--;
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
        stall = gap_len();
      end
      pop_i <= nxt;
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((push_i && !full_o) || (pop_i && !empty_o)) idle = 0;
      else idle++;
      if (idle >= WatchLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    spacing_q = prtw_pkg::SpacingReset;
    weight_q  = prtw_pkg::WeightReset;
    buffered  = 0;
    old_x = 0; old_y = 0; new_x = 0; new_y = 0;
    old_id = '0; new_id = '0; old_z = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_sweep();
    test_random();
    test_backpressure();
    if (errors == 0 && exp_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
